FILE: rtl/core/cumulative_sum_scan_defines.svh
// assertion helpers for the scan block; both sample on the rising clock edge
// and are switched off while reset is high
`ifndef CUMULATIVE_SUM_SCAN_DEFINES_SVH
`define CUMULATIVE_SUM_SCAN_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define CSS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CSS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/css_pkg.sv
package css_pkg;

   localparam int unsigned DataWidth     = 32;
   localparam int unsigned MaxLen        = 64;
   localparam int unsigned PosWidth      = $clog2(MaxLen);
   localparam int unsigned CountWidth    = PosWidth + 1;
   localparam int unsigned QueueDepth    = 2;
   localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);
   localparam int unsigned QueueCntWidth = QueuePtrWidth + 1;
   localparam int unsigned CsrIndexWidth = 2;

   localparam logic [CsrIndexWidth-1:0] CsrExclusiveMode = CsrIndexWidth'(0);
   localparam logic [CsrIndexWidth-1:0] CsrReverseMode   = CsrIndexWidth'(1);

   typedef struct packed {
      logic exclusive_mode;
      logic reverse_mode;
   } css_cfg_type;

   // one classified element on its way from the front to the back
   typedef struct packed {
      logic [DataWidth-1:0] element_value;
      logic [DataWidth-1:0] forward_sum;
      logic [PosWidth-1:0]  position;
      logic                 last;
      logic                 reverse;
      logic                 exclusive;
   } css_entry_type;

   typedef struct packed {
      logic                draining;
      logic [PosWidth-1:0] drain_pos;
   } css_back_stat_type;

endpackage

FILE: rtl/core/css_front.sv
module css_front (
   input  logic                          clock,
   input  logic                          reset,
   input  css_pkg::css_cfg_type          cfg,
   input  logic                          req_valid,
   input  logic [css_pkg::DataWidth-1:0] req_element_value,
   input  logic                          req_run_end,
   output logic                          req_stall,
   input  logic                          queue_full,
   output logic                          push,
   output css_pkg::css_entry_type        entry
);

   logic [css_pkg::DataWidth-1:0]  running_total_ff, running_total_in;
   logic [css_pkg::CountWidth-1:0] element_count_ff, element_count_in;
   logic [css_pkg::DataWidth-1:0]  total_after;
   logic                           last;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   assign total_after = running_total_ff + req_element_value;
   // run closes on the flag or when the buffer is about to fill
   assign last = req_run_end ||
                 (element_count_ff == css_pkg::CountWidth'(css_pkg::MaxLen - 1));

   always_comb begin
      entry.element_value = req_element_value;
      entry.forward_sum   = cfg.exclusive_mode ? running_total_ff : total_after;
      entry.position      = element_count_ff[css_pkg::PosWidth-1:0];
      entry.last          = last;
      entry.reverse       = cfg.reverse_mode;
      entry.exclusive     = cfg.exclusive_mode;
   end

   always_comb begin
      running_total_in = running_total_ff;
      element_count_in = element_count_ff;
      if (push) begin
         if (last) begin
            running_total_in = '0;
            element_count_in = '0;
         end else begin
            running_total_in = total_after;
            element_count_in = element_count_ff + css_pkg::CountWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_total_ff <= '0;
         element_count_ff <= '0;
      end else begin
         running_total_ff <= running_total_in;
         element_count_ff <= element_count_in;
      end
   end

endmodule

FILE: rtl/core/css_queue.sv
module css_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  css_pkg::css_entry_type push_entry,
   input  logic                   pop,
   output css_pkg::css_entry_type pop_entry,
   output logic                   full,
   output logic                   empty
);

   css_pkg::css_entry_type             slot_ff [css_pkg::QueueDepth];
   logic [css_pkg::QueuePtrWidth-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [css_pkg::QueuePtrWidth-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [css_pkg::QueueCntWidth-1:0]  fill_ff, fill_in;

   assign full      = (fill_ff == css_pkg::QueueCntWidth'(css_pkg::QueueDepth));
   assign empty     = (fill_ff == '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + css_pkg::QueuePtrWidth'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + css_pkg::QueuePtrWidth'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + css_pkg::QueueCntWidth'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - css_pkg::QueueCntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/core/css_back.sv
module css_back (
   input  logic                          clock,
   input  logic                          reset,
   input  css_pkg::css_entry_type        entry,
   input  logic                          queue_empty,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [css_pkg::DataWidth-1:0] rsp_scan_value,
   output logic [css_pkg::PosWidth-1:0]  rsp_position,
   output logic                          rsp_final_result,
   output css_pkg::css_back_stat_type    stat
);

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

   state_type                     state_ff, state_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [css_pkg::DataWidth-1:0] rsp_value_ff, rsp_value_in;
   logic [css_pkg::PosWidth-1:0]  rsp_pos_ff, rsp_pos_in;
   logic                          rsp_final_ff, rsp_final_in;
   logic [css_pkg::DataWidth-1:0] acc_ff, acc_in;
   logic                          excl_ff, excl_in;
   logic [css_pkg::PosWidth-1:0]  drain_pos_ff, drain_pos_in;

   logic [css_pkg::DataWidth-1:0] run_buffer_mem [css_pkg::MaxLen];
   logic [css_pkg::DataWidth-1:0] rd_data_ff;
   logic                          mem_we;
   logic                          rd_en;
   logic [css_pkg::PosWidth-1:0]  rd_addr;
   logic                          load_ok;
   logic [css_pkg::DataWidth-1:0] drain_sum;

   assign load_ok   = !rsp_valid_ff || !rsp_stall;
   assign drain_sum = acc_ff + rd_data_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_final_in = rsp_final_ff;
      acc_in       = acc_ff;
      excl_in      = excl_ff;
      drain_pos_in = drain_pos_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = drain_pos_ff - css_pkg::PosWidth'(1);
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty && load_ok) begin
               pop    = 1'b1;
               mem_we = 1'b1;
               if (!entry.reverse) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = entry.forward_sum;
                  rsp_pos_in   = entry.position;
                  rsp_final_in = entry.last;
               end else if (entry.last) begin
                  // newest element is at hand, so the drain starts without a read
                  rsp_valid_in = 1'b1;
                  rsp_value_in = entry.exclusive ? '0 : entry.element_value;
                  rsp_pos_in   = entry.position;
                  rsp_final_in = (entry.position == '0);
                  acc_in       = entry.element_value;
                  excl_in      = entry.exclusive;
                  if (entry.position != '0) begin
                     state_in     = ST_DRAIN;
                     drain_pos_in = entry.position - css_pkg::PosWidth'(1);
                     rd_en        = 1'b1;
                     rd_addr      = entry.position - css_pkg::PosWidth'(1);
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (load_ok) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = excl_ff ? acc_ff : drain_sum;
               rsp_pos_in   = drain_pos_ff;
               rsp_final_in = (drain_pos_ff == '0);
               acc_in       = drain_sum;
               if (drain_pos_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  drain_pos_in = drain_pos_ff - css_pkg::PosWidth'(1);
                  rd_en        = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_final_ff <= rsp_final_in;
      acc_ff       <= acc_in;
      excl_ff      <= excl_in;
      drain_pos_ff <= drain_pos_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         run_buffer_mem[entry.position] <= entry.element_value;
      end
      if (rd_en) begin
         rd_data_ff <= run_buffer_mem[rd_addr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scan_value   = rsp_value_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_final_result = rsp_final_ff;
   assign stat.draining    = (state_ff == ST_DRAIN);
   assign stat.drain_pos   = drain_pos_ff;

endmodule

FILE: rtl/core/cumulative_sum_scan.sv
// path: a forward result passes through a queue slot and the output register before it shows on rsp
// throughput, with rsp_stall low: one element per cycle in forward mode; a reverse run of
//   n elements drains n results at one per cycle after its last element, set by the buffer read port
// reset: synchronous, active high; clears modes, running sum, count, queue and output valid
// the run buffer is not cleared; entries are only read after being written in the same run
`include "cumulative_sum_scan_defines.svh"

module cumulative_sum_scan (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [31:0]                req_element_value,
   input  logic                              req_run_end,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [31:0]                rsp_scan_value,
   output logic [5:0]                        rsp_position,
   output logic                              rsp_final_result,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [css_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic                              csr_data
);

   css_pkg::css_cfg_type          cfg_ff, cfg_in;
   css_pkg::css_entry_type        push_entry;
   css_pkg::css_entry_type        pop_entry;
   css_pkg::css_back_stat_type    back_stat;
   logic                          q_push;
   logic                          q_pop;
   logic                          q_full;
   logic                          q_empty;
   logic [css_pkg::DataWidth-1:0] scan_value;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            css_pkg::CsrExclusiveMode: cfg_in.exclusive_mode = csr_data;
            css_pkg::CsrReverseMode:   cfg_in.reverse_mode   = csr_data;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   css_front u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_element_value ($unsigned(req_element_value)),
      .req_run_end       (req_run_end),
      .req_stall         (req_stall),
      .queue_full        (q_full),
      .push              (q_push),
      .entry             (push_entry)
   );

   css_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   css_back u_back (
      .clock            (clock),
      .reset            (reset),
      .entry            (pop_entry),
      .queue_empty      (q_empty),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_scan_value   (scan_value),
      .rsp_position     (rsp_position),
      .rsp_final_result (rsp_final_result),
      .stat             (back_stat)
   );

   assign rsp_scan_value = $signed(scan_value);

   // while a reverse drain runs the held result is never the run's last one
   `CSS_ASSERT_NOW(a_drain_not_final, back_stat.draining, !(rsp_valid && rsp_final_result), "final result during drain")
   // the held result sits one position above the next one to be read
   `CSS_ASSERT_NOW(a_drain_position, back_stat.draining && rsp_valid, rsp_position == back_stat.drain_pos + 6'd1, "drain position out of order")
   // a result only appears after a queue pop or a drain step
   `CSS_ASSERT_NOW(a_result_source, $rose(rsp_valid), $past(q_pop || back_stat.draining), "result without source transaction")

endmodule
